// ----- src/logistic_map_bifurcation_sweep_defines.svh -----
// Assertion macros for the logistic map sweep checker.
// No dependencies; included by the checker file only.
`ifndef LOGISTIC_MAP_BIFURCATION_SWEEP_DEFINES_SVH
`define LOGISTIC_MAP_BIFURCATION_SWEEP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LMBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LMBS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lmbs_pkg.sv -----
// Shared constants for the logistic map bifurcation sweep.
// No dependencies; used by the top level and the checker.
package lmbs_pkg;

  localparam int FRAC_BITS_DEFAULT  = 16;
  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int CFG_INDEX_BITS     = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_R_MIN        = 3'd0,
    REG_R_STEP       = 3'd1,
    REG_R_COUNT      = 3'd2,
    REG_X_START      = 3'd3,
    REG_WARMUP_ITERS = 3'd4,
    REG_RECORD_ITERS = 3'd5
  } cfg_reg_t;

endpackage

// ----- src/lmbs_mul.sv -----
// Shared unsigned multiplier with registered product.
// No package dependencies; instantiated by the sweep top level.
module lmbs_mul #(
  parameter int A_BITS = 19,
  parameter int B_BITS = 17
) (
  input  logic                     clk,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic [A_BITS+B_BITS-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
  end

endmodule

// ----- src/logistic_map_bifurcation_sweep.sv -----
// Logistic map bifurcation sweep generator: sequencer, counters, output register.
// Depends on lmbs_pkg and lmbs_mul.
//
//  channel   | direction | contents
//  s_axis    | in        | tdata[0] restart
//  m_axis    | out       | tdata sample, rate_index, sample_index; tlast last_of_row;
//            |           | tuser last_of_sweep
//  cfg       | in        | register write, index 0..5
//
// A word with restart clear passes through accept, x*(1-x) and r*t on the one
// shared multiplier, then writeback of x. Restart, or a word after the sweep has
// finished, stays in the accept state. rst is synchronous and loads the default
// registers. Input is held off while the output word waits and is not taken.
module logistic_map_bifurcation_sweep #(
  parameter int FRAC_BITS  = lmbs_pkg::FRAC_BITS_DEFAULT,
  parameter int COUNT_BITS = lmbs_pkg::COUNT_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [0] restart
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // sample, rate_index, sample_index from bit 0 up, zero padded
  output logic [((FRAC_BITS+1+2*COUNT_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast,        // last_of_row
  output logic m_axis_tuser,        // last_of_sweep
  input  logic cfg_we,
  input  logic [lmbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((FRAC_BITS+3 > COUNT_BITS) ? FRAC_BITS+3 : COUNT_BITS)-1:0] cfg_data
);

  localparam int X_BITS = FRAC_BITS + 1;
  localparam int R_BITS = FRAC_BITS + 3;
  localparam int P_BITS = R_BITS + X_BITS;
  localparam int Y_BITS = P_BITS - FRAC_BITS;
  localparam int OUT_W  = ((X_BITS + 2*COUNT_BITS + 7) / 8) * 8;
  localparam logic [X_BITS-1:0] ONE = X_BITS'(1) << FRAC_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef enum logic [1:0] {S_IDLE, S_MUL1, S_MUL2, S_WB} seq_state_t;

  seq_state_t state;

  // configuration registers
  logic [R_BITS-1:0]     r_min, r_step;
  logic [COUNT_BITS-1:0] r_count, warmup_iters, record_iters;
  logic [X_BITS-1:0]     x_start;

  // sweep state
  logic [X_BITS-1:0]     map_value;
  logic [R_BITS-1:0]     current_rate;
  logic [COUNT_BITS-1:0] rate_counter, iteration_counter;
  logic                  in_warmup, sweep_finished, row_adv;

  // output register
  logic                  out_valid, out_last_row, out_last_sweep;
  logic [X_BITS-1:0]     out_sample;
  logic [COUNT_BITS-1:0] out_rate, out_idx;

  logic                  in_fire, restart, out_load;
  logic [X_BITS-1:0]     x_start_sat, y_sat;
  logic [COUNT_BITS-1:0] rec_eff, cnt_eff;
  logic [COUNT_BITS:0]   iter_inc, rate_inc;
  logic                  warm_done, row_end, sweep_end;
  logic [R_BITS:0]       rate_sum;
  logic [R_BITS-1:0]     rate_sat, mul_a;
  logic [X_BITS-1:0]     mul_b;
  logic [P_BITS-1:0]     prod;
  logic [Y_BITS-1:0]     y;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign restart  = s_axis_tdata[0];
  // recorded tick: a sweep word goes into the output register
  assign out_load = in_fire && !restart && !sweep_finished && !in_warmup;

  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);

  assign x_start_sat = (x_start > ONE) ? ONE : x_start;
  assign rec_eff     = (record_iters == '0) ? CNT_ONE : record_iters;
  assign cnt_eff     = (r_count == '0) ? CNT_ONE : r_count;
  assign iter_inc    = {1'b0, iteration_counter} + (COUNT_BITS+1)'(1);
  assign rate_inc    = {1'b0, rate_counter} + (COUNT_BITS+1)'(1);
  assign warm_done   = iter_inc >= {1'b0, warmup_iters};
  assign row_end     = iter_inc >= {1'b0, rec_eff};
  assign sweep_end   = row_end && (rate_inc >= {1'b0, cnt_eff});

  assign rate_sum = {1'b0, current_rate} + {1'b0, r_step};
  assign rate_sat = rate_sum[R_BITS] ? {R_BITS{1'b1}} : rate_sum[R_BITS-1:0];

  // first pass: x * (ONE - x); second pass: r * t, t taken from the first product
  always_comb begin
    if (state == S_MUL2) begin
      mul_a = current_rate;
      mul_b = {1'b0, prod[2*FRAC_BITS-1:FRAC_BITS]};
    end else begin
      mul_a = R_BITS'(map_value);
      mul_b = ONE - map_value;
    end
  end

  lmbs_mul #(
    .A_BITS(R_BITS),
    .B_BITS(X_BITS)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign y     = prod[P_BITS-1:FRAC_BITS];
  assign y_sat = (y > Y_BITS'(ONE)) ? ONE : y[X_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      r_min             <= '0;
      r_step            <= '0;
      r_count           <= CNT_ONE;
      x_start           <= ONE >> 1;
      warmup_iters      <= '0;
      record_iters      <= CNT_ONE;
      map_value         <= ONE >> 1;
      current_rate      <= '0;
      rate_counter      <= '0;
      iteration_counter <= '0;
      in_warmup         <= 1'b0;
      sweep_finished    <= 1'b0;
      row_adv           <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          lmbs_pkg::REG_R_MIN:        r_min        <= cfg_data[R_BITS-1:0];
          lmbs_pkg::REG_R_STEP:       r_step       <= cfg_data[R_BITS-1:0];
          lmbs_pkg::REG_R_COUNT:      r_count      <= cfg_data[COUNT_BITS-1:0];
          lmbs_pkg::REG_X_START:      x_start      <= cfg_data[X_BITS-1:0];
          lmbs_pkg::REG_WARMUP_ITERS: warmup_iters <= cfg_data[COUNT_BITS-1:0];
          lmbs_pkg::REG_RECORD_ITERS: record_iters <= cfg_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (restart) begin
              map_value         <= x_start_sat;
              current_rate      <= r_min;
              rate_counter      <= '0;
              iteration_counter <= '0;
              in_warmup         <= warmup_iters != '0;
              sweep_finished    <= 1'b0;
            end else if (!sweep_finished) begin
              state   <= S_MUL1;
              row_adv <= 1'b0;
              if (in_warmup) begin
                if (warm_done) begin
                  in_warmup         <= 1'b0;
                  iteration_counter <= '0;
                end else begin
                  iteration_counter <= iter_inc[COUNT_BITS-1:0];
                end
              end else begin
                out_sample     <= map_value;
                out_rate       <= rate_counter;
                out_idx        <= iteration_counter;
                out_last_row   <= row_end;
                out_last_sweep <= sweep_end;
                if (sweep_end) begin
                  sweep_finished <= 1'b1;
                end else if (row_end) begin
                  // new row: x and rate are reloaded at writeback
                  rate_counter      <= rate_inc[COUNT_BITS-1:0];
                  iteration_counter <= '0;
                  in_warmup         <= warmup_iters != '0;
                  row_adv           <= 1'b1;
                end else begin
                  iteration_counter <= iter_inc[COUNT_BITS-1:0];
                end
              end
            end
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_WB;
        S_WB: begin
          map_value <= row_adv ? x_start_sat : y_sat;
          if (row_adv) begin
            current_rate <= rate_sat;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({out_idx, out_rate, out_sample});
  assign m_axis_tlast  = out_last_row;
  assign m_axis_tuser  = out_last_sweep;

endmodule

// ----- src/lmbs_checker.sv -----
// Port-level checker for the logistic map sweep, bound to the top level.
// Depends on lmbs_pkg and logistic_map_bifurcation_sweep_defines.svh.
`include "logistic_map_bifurcation_sweep_defines.svh"

module lmbs_checker #(
  parameter int FRAC_BITS  = lmbs_pkg::FRAC_BITS_DEFAULT,
  parameter int COUNT_BITS = lmbs_pkg::COUNT_BITS_DEFAULT
) (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((FRAC_BITS+1+2*COUNT_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic m_axis_tlast,
  input logic m_axis_tuser
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // stalled output word holds
  `LMBS_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output word changed while stalled")

  // a restart word never yields a result
  `LMBS_ASSERT_NXT(a_restart_silent, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tdata[0] && !m_axis_tvalid, !m_axis_tvalid, "result after restart")

  // end of sweep is always end of row
  `LMBS_ASSERT_IMP(a_sweep_row, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "last_of_sweep without last_of_row")

  // sample stays within [0, 1]
  `LMBS_ASSERT_IMP(a_sample_range, clk, rst, m_axis_tvalid, m_axis_tdata[FRAC_BITS:0] <= ONE, "sample above one")

  // no new word taken while the output is full and stalled
  `LMBS_ASSERT_IMP(a_no_overrun, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")

endmodule

bind logistic_map_bifurcation_sweep lmbs_checker #(
  .FRAC_BITS  (FRAC_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_lmbs_checker (.*);
